### rtl/core/multichannel_peak_energy_vector_top_macros.svh
// ----------------------------------------------------------------------------
// multichannel peak energy vector assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PEAK_ENERGY_VECTOR_TOP_MACROS_SVH
`define MULTICHANNEL_PEAK_ENERGY_VECTOR_TOP_MACROS_SVH

// same-cycle implication
`define MPEV_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MPEV_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mpev_pkg.sv
// ----------------------------------------------------------------------------
// mpev_pkg
// shared constants, types and the quarter-wave sine table
// ----------------------------------------------------------------------------
package mpev_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int SAMPLE_BITS  = 24;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
	localparam int WSHIFT       = (2 * SAMPLE_BITS > 42) ? 2 * SAMPLE_BITS - 42 : 0;
	localparam int W_W          = 2 * SAMPLE_BITS - WSHIFT;
	localparam int ACC_W        = W_W + 16 + CH_W;
	localparam int TOT_W        = W_W + CH_W;
	localparam int Q_W          = 16;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic REG_NUM_CHANNELS   = 1'b0;
	localparam logic REG_DIRECTION_STEP = 1'b1;

	localparam logic [6:0]  NUM_CHANNELS_RST   = 7'd8;
	localparam logic [15:0] DIRECTION_STEP_RST = 16'd8192;

	localparam logic signed [12:0] LEVEL_FLOOR     = -13'sd2400;
	localparam logic [12:0]        LEVEL_FLOOR_MAG = 13'd2400;
	localparam logic [22:0]        DB_PER_LOG2_Q16 = 23'd6313057;
	localparam logic [3:0]         SEGMENT_MAX     = 4'd14;
	localparam logic [14:0]        INV48_Q20       = 15'd21846;

	typedef struct packed {
		logic                          rd_en;
		logic [CH_W-1:0]               rd_addr;
		logic                          wr_en;
		logic [CH_W-1:0]               wr_addr;
		logic signed [SAMPLE_BITS-1:0] wr_data;
		logic                          clr_en;
		logic [CH_W-1:0]               clr_addr;
	} mem_req_t;

	function automatic logic [15:0] quarter_tbl(input logic [4:0] idx);
		logic [15:0] v;
		unique case (idx)
			5'd0:  v = 16'd0;
			5'd1:  v = 16'd3212;
			5'd2:  v = 16'd6393;
			5'd3:  v = 16'd9512;
			5'd4:  v = 16'd12539;
			5'd5:  v = 16'd15446;
			5'd6:  v = 16'd18204;
			5'd7:  v = 16'd20787;
			5'd8:  v = 16'd23170;
			5'd9:  v = 16'd25329;
			5'd10: v = 16'd27245;
			5'd11: v = 16'd28898;
			5'd12: v = 16'd30273;
			5'd13: v = 16'd31356;
			5'd14: v = 16'd32137;
			5'd15: v = 16'd32609;
			default: v = 16'd32767;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] quarter_lookup(input logic [14:0] r);
		logic [4:0]  idx;
		logic [9:0]  frac;
		logic [15:0] lo;
		logic [15:0] diff;
		logic [25:0] prod;
		idx  = {1'b0, r[13:10]};
		frac = r[9:0];
		lo   = quarter_tbl(idx);
		diff = quarter_tbl(idx + 5'd1) - lo;
		prod = 26'(diff) * 26'(frac) + 26'd512;
		if (r[14])
			return 16'd32767;
		return lo + 16'(prod[25:10]);
	endfunction

	function automatic logic signed [15:0] sine_q15(input logic [15:0] phase);
		logic [14:0] r;
		logic [15:0] v;
		r = {1'b0, phase[13:0]};
		v = phase[14] ? quarter_lookup(15'd16384 - r) : quarter_lookup(r);
		return phase[15] ? -$signed(v) : $signed(v);
	endfunction

endpackage

### rtl/core/multichannel_peak_energy_vector_top.sv
// ----------------------------------------------------------------------------
// multichannel_peak_energy_vector_top
// per-channel peak hold with dB meter report and energy vector
// ----------------------------------------------------------------------------
// Input words (s_*) are samples (tuser 0) or ticks (tuser 1). A sample reads
// the peak memory, then compares and writes back before the next word is
// taken. Samples for channels at or above the channel count are dropped.
// A tick walks min(num_channels, 16) channels and gives one output word per
// channel, each paced by the log2 unit that resolves one fraction bit per
// cycle. The last word carries the energy vector and tlast; once its level
// is ready it waits in the shared divider, first for x and then for y, or
// goes straight out when all peaks are zero. Peaks clear as walked.
// The output sits in one register; a stall on m_tready holds the walk, and
// the next input word is taken while the final word still waits there.
// Reset clears all peaks at once and loads num_channels 8 and
// direction_step 8192. Write the registers through the APB port at 0x0 and
// 0x4 only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "multichannel_peak_energy_vector_top_macros.svh"

module multichannel_peak_energy_vector_top import mpev_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // channel[5:0], sample[29:6]
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // chan_index, level_db, segment, vector_x, vector_y
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SMP     = 4'd1;
	localparam logic [3:0] ST_T_RD    = 4'd2;
	localparam logic [3:0] ST_T_DAT   = 4'd3;
	localparam logic [3:0] ST_T_LOG   = 4'd4;
	localparam logic [3:0] ST_T_EMIT  = 4'd5;
	localparam logic [3:0] ST_DX_GO   = 4'd6;
	localparam logic [3:0] ST_DX_WAIT = 4'd7;
	localparam logic [3:0] ST_DY_GO   = 4'd8;
	localparam logic [3:0] ST_DY_WAIT = 4'd9;
	localparam logic [3:0] ST_FIN     = 4'd10;

	logic [6:0]  num_channels_q;
	logic [15:0] direction_step_q;
	logic [3:0]  state_q;
	logic [CH_W-1:0] chan_q;
	logic [15:0] phase_q;
	logic signed [SAMPLE_BITS-1:0] smp_val_q;
	logic [CH_W-1:0] smp_ch_q;
	logic        smp_hit_q;
	logic signed [12:0] lvl_q;
	logic signed [ACC_W-1:0] sx_q;
	logic signed [ACC_W-1:0] sy_q;
	logic [TOT_W-1:0] tot_q;
	logic signed [Q_W-1:0] vx_q;
	logic signed [Q_W-1:0] vy_q;

	logic [W_W-1:0] w_s1;
	logic signed [15:0] cos_s1;
	logic signed [15:0] sin_s1;
	logic        v_s1;
	logic signed [W_W+16:0] px_s2;
	logic signed [W_W+16:0] py_s2;
	logic [W_W-1:0] w_s2;
	logic        v_s2;

	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;
	logic        m_tlast_q;

	logic [CNT_W-1:0] count;
	logic        in_acc;
	logic        cfg_wr;
	logic        out_free;
	logic        is_last;
	logic        emit_go;
	mem_req_t    mreq;
	logic signed [SAMPLE_BITS-1:0] rd_data;
	logic [SAMPLE_BITS-1:0] rd_mag;
	logic [SAMPLE_BITS-1:0] smp_mag;
	logic        log_done;
	logic signed [12:0] log_level;
	logic        div_start;
	logic        div_done;
	logic signed [Q_W-1:0] div_quot;
	logic [2*SAMPLE_BITS-1:0] msq;
	logic [11:0] lvl_mag;
	logic [26:0] seg_prod;
	logic [3:0]  seg;
	logic [5:0]  in_ch;
	logic signed [SAMPLE_BITS-1:0] in_smp;

	assign in_ch    = s_tdata[5:0];
	assign in_smp   = s_tdata[29:6];
	assign count    = (num_channels_q > 7'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
		: CNT_W'(num_channels_q);
	assign s_tready = state_q == ST_IDLE;
	assign in_acc   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_DIRECTION_STEP) ? 32'(direction_step_q)
		: 32'(num_channels_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign is_last  = {1'b0, chan_q} == count - CNT_W'(1);
	assign emit_go  = (state_q == ST_T_EMIT && out_free && !v_s1 && !v_s2 && !is_last)
		|| (state_q == ST_FIN && out_free);

	assign rd_mag  = rd_data[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_data) : rd_data;
	assign smp_mag = smp_val_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp_val_q) : smp_val_q;
	assign msq     = (2*SAMPLE_BITS)'(rd_mag) * (2*SAMPLE_BITS)'(rd_mag);

	always_comb begin
		lvl_mag  = 12'(-lvl_q);
		seg_prod = 27'(lvl_mag) * 27'(INV48_Q20);
		seg      = (seg_prod[26:20] > 7'(SEGMENT_MAX)) ? SEGMENT_MAX : seg_prod[23:20];
	end

	always_comb begin
		mreq = '0;
		if (in_acc && s_tuser == OP_SAMPLE) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = in_ch[CH_W-1:0];
		end else if (state_q == ST_T_RD) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = chan_q;
		end
		mreq.wr_en    = state_q == ST_SMP && smp_hit_q && smp_mag > rd_mag;
		mreq.wr_addr  = smp_ch_q;
		mreq.wr_data  = smp_val_q;
		mreq.clr_en   = state_q == ST_T_EMIT && out_free;
		mreq.clr_addr = chan_q;
	end

	assign div_start = state_q == ST_DX_GO || state_q == ST_DY_GO;

	mpev_peak_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (rd_data)
	);

	mpev_log_unit u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_T_DAT),
		.mag    (rd_mag),
		.done   (log_done),
		.level  (log_level)
	);

	mpev_div_unit u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ((state_q == ST_DX_GO) ? sx_q : sy_q),
		.divisor  (tot_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q   <= NUM_CHANNELS_RST;
			direction_step_q <= DIRECTION_STEP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_NUM_CHANNELS:   num_channels_q   <= pwdata[6:0];
				REG_DIRECTION_STEP: direction_step_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		w_s1   <= W_W'(msq >> WSHIFT);
		cos_s1 <= sine_q15(phase_q + 16'd16384);
		sin_s1 <= sine_q15(phase_q);
		px_s2  <= $signed({1'b0, w_s1}) * cos_s1;
		py_s2  <= $signed({1'b0, w_s1}) * sin_s1;
		w_s2   <= w_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_T_DAT;
			v_s2 <= v_s1;
			if (v_s2) begin
				sx_q  <= sx_q + ACC_W'(px_s2);
				sy_q  <= sy_q + ACC_W'(py_s2);
				tot_q <= tot_q + TOT_W'(w_s2);
			end
			if (emit_go)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == OP_SAMPLE) begin
							smp_val_q <= in_smp;
							smp_ch_q  <= in_ch[CH_W-1:0];
							smp_hit_q <= 7'(in_ch) < 7'(count);
							state_q   <= ST_SMP;
						end else if (count != '0) begin
							chan_q  <= '0;
							phase_q <= '0;
							sx_q    <= '0;
							sy_q    <= '0;
							tot_q   <= '0;
							state_q <= ST_T_RD;
						end
					end
				end
				ST_SMP:   state_q <= ST_IDLE;
				ST_T_RD:  state_q <= ST_T_DAT;
				ST_T_DAT: state_q <= ST_T_LOG;
				ST_T_LOG: begin
					if (log_done) begin
						lvl_q   <= log_level;
						state_q <= ST_T_EMIT;
					end
				end
				ST_T_EMIT: begin
					if (out_free && !v_s1 && !v_s2) begin
						if (is_last) begin
							vx_q    <= '0;
							vy_q    <= '0;
							state_q <= (tot_q == '0) ? ST_FIN : ST_DX_GO;
						end else begin
							m_tlast_q  <= 1'b0;
							m_tdata_q  <= {1'b0, 32'd0, seg, lvl_q, 6'(chan_q)};
							chan_q     <= chan_q + 1'b1;
							phase_q    <= phase_q - direction_step_q;
							state_q    <= ST_T_RD;
						end
					end
				end
				ST_DX_GO: state_q <= ST_DX_WAIT;
				ST_DX_WAIT: begin
					if (div_done) begin
						vx_q    <= div_quot;
						state_q <= ST_DY_GO;
					end
				end
				ST_DY_GO: state_q <= ST_DY_WAIT;
				ST_DY_WAIT: begin
					if (div_done) begin
						vy_q    <= div_quot;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tlast_q  <= 1'b1;
						m_tdata_q  <= {1'b0, vy_q, vx_q, seg, lvl_q, 6'(chan_q)};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`MPEV_CHECK(a_log_done_in_walk, log_done, state_q == ST_T_LOG, "log result outside walk")
	`MPEV_CHECK(a_div_done_in_wait, div_done,
		state_q == ST_DX_WAIT || state_q == ST_DY_WAIT, "divider result unexpected")
	`MPEV_CHECK_NEXT(a_walk_advance, state_q == ST_T_EMIT && out_free && !v_s1 && !v_s2
		&& !is_last, state_q == ST_T_RD && chan_q == $past(chan_q) + 1'b1,
		"walk did not advance")

endmodule

### rtl/core/mpev_peak_mem.sv
// ----------------------------------------------------------------------------
// mpev_peak_mem
// per-channel peak store, registered read, valid bits clear on reset
// ----------------------------------------------------------------------------
module mpev_peak_mem import mpev_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mem_req_t                      req,
	output logic signed [SAMPLE_BITS-1:0] rd_data
);

	logic signed [SAMPLE_BITS-1:0] mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0]       valid_q;
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic                          rv_q;

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rd_q <= mem[req.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (req.rd_en)
				rv_q <= valid_q[req.rd_addr];
			if (req.clr_en)
				valid_q[req.clr_addr] <= 1'b0;
			if (req.wr_en)
				valid_q[req.wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rv_q ? rd_q : '0;

endmodule

### rtl/core/mpev_log_unit.sv
// ----------------------------------------------------------------------------
// mpev_log_unit
// peak magnitude to level in 1/16 dB, one log2 fraction bit per cycle
// ----------------------------------------------------------------------------
module mpev_log_unit import mpev_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] mag,
	output logic                   done,
	output logic signed [12:0]     level
);

	localparam logic [1:0] LG_IDLE = 2'd0;
	localparam logic [1:0] LG_STEP = 2'd1;
	localparam logic [1:0] LG_MULT = 2'd2;
	localparam logic [1:0] LG_FIN  = 2'd3;

	logic [1:0]  st_q;
	logic [3:0]  cnt_q;
	logic [31:0] x_q;
	logic [4:0]  e_q;
	logic [15:0] frac_q;
	logic [43:0] prod_q;
	logic        done_q;
	logic signed [12:0] level_q;

	logic [4:0]  e;
	logic [63:0] sq;
	logic [32:0] t;
	logic [20:0] a;
	logic [44:0] rnd;
	logic [12:0] r;

	always_comb begin
		e = '0;
		for (int i = 0; i < SAMPLE_BITS; i++)
			if (mag[i])
				e = 5'(i);
		sq  = 64'(x_q) * 64'(x_q);
		t   = sq[63:31];
		a   = 21'((SAMPLE_BITS - 1) * 65536) - {e_q, frac_q};
		rnd = 45'(prod_q) + 45'h0_8000_0000;
		r   = rnd[44:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= LG_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				LG_IDLE: begin
					if (start) begin
						if (mag == '0) begin
							level_q <= LEVEL_FLOOR;
							done_q  <= 1'b1;
						end else begin
							x_q    <= 32'(mag) << (5'd31 - e);
							e_q    <= e;
							frac_q <= '0;
							cnt_q  <= '0;
							st_q   <= LG_STEP;
						end
					end
				end
				LG_STEP: begin
					if (t[32]) begin
						x_q    <= t[32:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						x_q    <= t[31:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						st_q <= LG_MULT;
				end
				LG_MULT: begin
					prod_q <= 44'(a) * 44'(DB_PER_LOG2_Q16);
					st_q   <= LG_FIN;
				end
				LG_FIN: begin
					level_q <= (r > LEVEL_FLOOR_MAG) ? LEVEL_FLOOR : -$signed(r);
					done_q  <= 1'b1;
					st_q    <= LG_IDLE;
				end
				default: st_q <= LG_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign level = level_q;

endmodule

### rtl/core/mpev_div_unit.sv
// ----------------------------------------------------------------------------
// mpev_div_unit
// signed by unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mpev_div_unit import mpev_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] dividend,
	input  logic [TOT_W-1:0]        divisor,
	output logic                    done,
	output logic signed [Q_W-1:0]   quot
);

	logic                   busy_q;
	logic                   done_q;
	logic                   neg_q;
	logic [ACC_W-1:0]       r_q;
	logic [TOT_W+Q_W-2:0]   d_q;
	logic [Q_W-1:0]         q_q;
	logic [$clog2(Q_W)-1:0] cnt_q;
	logic                   ge;

	assign ge = r_q >= ACC_W'(d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= dividend[ACC_W-1];
				r_q    <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
				d_q    <= {divisor, {(Q_W-1){1'b0}}};
				q_q    <= '0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (ge)
					r_q <= r_q - ACC_W'(d_q);
				q_q   <= {q_q[Q_W-2:0], ge};
				d_q   <= d_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives sample and tick words into the peak meter, predicts each channel's
// level, segment and energy vector, and checks the output words in order
// ----------------------------------------------------------------------------
module tb;
	import mpev_pkg::*;

	typedef struct {
		logic [5:0]         chan;
		logic signed [12:0] level;
		logic [3:0]         seg;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic               last;
	} level_word_t;

	class peak_scoreboard;
		longint      peaks[MAX_CHANNELS];
		int unsigned chan_cfg;
		int unsigned step_cfg;
		level_word_t expected_words[$];
		int          errors;

		function new();
			foreach (peaks[i]) peaks[i] = 0;
			chan_cfg = NUM_CHANNELS_RST;
			step_cfg = DIRECTION_STEP_RST;
			errors = 0;
		endfunction

		function int quarter(int unsigned r);
			int tbl[17] = '{0, 3212, 6393, 9512, 12539, 15446, 18204, 20787, 23170,
				25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767};
			int unsigned idx;
			int unsigned frac;
			if (r >= 16384)
				return 32767;
			idx = r >> 10;
			frac = r & 10'h3ff;
			return tbl[idx] + int'(((tbl[idx+1] - tbl[idx]) * frac + 512) >> 10);
		endfunction

		function longint sine(int unsigned phase);
			int unsigned r;
			int          v;
			phase = phase & 16'hffff;
			r = phase & 14'h3fff;
			v = phase[14] ? quarter(16384 - r) : quarter(r);
			return phase[15] ? -v : v;
		endfunction

		function int level_of(longint unsigned m);
			int              e;
			longint unsigned x;
			longint unsigned lg;
			longint unsigned a;
			longint          lvl;
			if (m == 0)
				return -2400;
			e = 0;
			for (int i = 0; i < 63; i++)
				if (m[i])
					e = i;
			x = m << (31 - e);
			lg = longint'(e) << 16;
			for (int i = 0; i < 16; i++) begin
				x = (x * x) >> 31;
				if (x >= 64'h1_0000_0000) begin
					lg = lg | (64'd1 << (15 - i));
					x = x >> 1;
				end
			end
			a = (longint'(SAMPLE_BITS - 1) << 16) - lg;
			lvl = -longint'((a * 64'd6313057 + 64'h8000_0000) >> 32);
			if (lvl < -2400)
				lvl = -2400;
			return int'(lvl);
		endfunction

		function void configure(int idx, int unsigned value);
			if (idx == REG_NUM_CHANNELS)
				chan_cfg = value & 7'h7f;
			else
				step_cfg = value & 16'hffff;
		endfunction

		function void note_input(logic op, logic [5:0] ch, logic signed [23:0] smp);
			int unsigned     count;
			longint          sx;
			longint          sy;
			longint          total;
			longint unsigned m;
			longint          w;
			int              lvl;
			int              sg;
			int unsigned     phase;
			level_word_t     wd;
			count = chan_cfg > MAX_CHANNELS ? MAX_CHANNELS : chan_cfg;
			if (op == OP_SAMPLE) begin
				if (ch < count && (smp < 0 ? -longint'(smp) : longint'(smp)) >
						(peaks[ch] < 0 ? -peaks[ch] : peaks[ch]))
					peaks[ch] = smp;
				return;
			end
			sx = 0;
			sy = 0;
			total = 0;
			for (int i = 0; i < count; i++) begin
				m = peaks[i] < 0 ? -peaks[i] : peaks[i];
				lvl = level_of(m);
				sg = (-lvl) / 48;
				if (sg > 14)
					sg = 14;
				phase = (0 - i * step_cfg) & 16'hffff;
				w = (m * m) >> WSHIFT;
				sx += w * sine(phase + 16384);
				sy += w * sine(phase);
				total += w;
				wd.chan = 6'(i);
				wd.level = 13'(lvl);
				wd.seg = 4'(sg);
				wd.vx = 0;
				wd.vy = 0;
				wd.last = 0;
				if (i == count - 1) begin
					wd.last = 1;
					if (total != 0) begin
						wd.vx = 16'(sx / total);
						wd.vy = 16'(sy / total);
					end
				end
				expected_words.push_back(wd);
				peaks[i] = 0;
			end
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(logic [55:0] d, logic tl);
			level_word_t e;
			if (expected_words.size() == 0) begin
				report("unexpected word", d[5:0], -1);
				return;
			end
			e = expected_words.pop_front();
			if (d[5:0] !== e.chan) report("chan_index", d[5:0], e.chan);
			if ($signed(d[18:6]) !== e.level) report("level_db", $signed(d[18:6]), e.level);
			if (d[22:19] !== e.seg) report("segment", d[22:19], e.seg);
			if ($signed(d[38:23]) !== e.vx) report("vector_x", $signed(d[38:23]), e.vx);
			if ($signed(d[54:39]) !== e.vy) report("vector_y", $signed(d[54:39]), e.vy);
			if (tl !== e.last) report("last", tl, e.last);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	peak_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_len;
	int quiet_cycles;

	multichannel_peak_energy_vector_top dut (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task send_word(logic op, logic [5:0] ch, logic signed [23:0] smp);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {2'b00, smp, ch};
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, ch, smp);
	endtask

	task drain();
		s_tvalid <= 0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.configure(addr >> 2, data);
	endtask

	function logic signed [23:0] rand_sample();
		logic signed [23:0] v;
		v = 24'($urandom);
		if ($urandom_range(1))
			v = v >>> $urandom_range(22);
		return v;
	endfunction

	task random_items(int n);
		int unsigned count;
		for (int k = 0; k < n; k++) begin
			count = sb.chan_cfg > MAX_CHANNELS ? MAX_CHANNELS : sb.chan_cfg;
			if ($urandom_range(99) < 9)
				send_word(OP_TICK, 6'($urandom), 24'($urandom));
			else if (count > 0 && $urandom_range(99) < 88)
				send_word(OP_SAMPLE, 6'($urandom_range(count - 1)), rand_sample());
			else
				send_word(OP_SAMPLE, 6'($urandom_range(63)), rand_sample());
		end
	endtask

	initial begin
		int cfg_ch[8] = '{8, 3, 16, 64, 0, 5, 17, 12};
		int cfg_st[8] = '{8192, 21845, 4096, 0, 65535, 65535, 3855, 5461};
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		m_tready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		hold_len = 0;
		quiet_cycles = 0;
		send_idle_pct = 27;
		recv_idle_pct = 51;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes under reset settings
		send_word(OP_TICK, 0, 0);
		send_word(OP_SAMPLE, 0, 24'sh800000);
		send_word(OP_SAMPLE, 1, 24'sh7fffff);
		send_word(OP_SAMPLE, 2, 24'sd1);
		send_word(OP_SAMPLE, 3, -24'sd1);
		send_word(OP_SAMPLE, 4, 24'sd1000);
		send_word(OP_SAMPLE, 4, -24'sd999);
		send_word(OP_SAMPLE, 5, 24'sh7fffff);
		send_word(OP_SAMPLE, 5, 24'sh800000);
		send_word(OP_SAMPLE, 7, 24'sd77);
		send_word(OP_SAMPLE, 8, 24'sh7fffff);
		send_word(OP_SAMPLE, 63, 24'sh800000);
		send_word(OP_TICK, 6'h3f, 24'hffffff);
		send_word(OP_SAMPLE, 6, 24'sd12345);
		send_word(OP_TICK, 0, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 27;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			apb_write(3'd0, cfg_ch[p]);
			apb_write(3'd4, cfg_st[p]);
			random_items(25);
			if (p == 2) begin
				// long receiver hold while input keeps coming
				hold_len = 500;
				for (int k = 0; k < 4; k++) begin
					send_word(OP_SAMPLE, 6'(k), rand_sample());
					send_word(OP_TICK, 0, 0);
				end
			end
			if (p == 5) begin
				s_tvalid <= 0;
				while (sb.expected_words.size() != 0) @(posedge clk);
			end
			random_items(25);
			drain();
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
